// ===== rtl/core/servo_angle_sweep_controller_core_macros.svh =====
// Assertion macros shared by the servo sweep controller core.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SERVO_ANGLE_SWEEP_CONTROLLER_CORE_MACROS_SVH
`define SERVO_ANGLE_SWEEP_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SASC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SASC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sasc_pkg.sv =====
// Types, codes and constants of the servo sweep controller core.
// Used by every module of the core; depends on nothing.
package sasc_pkg;

  localparam int unsigned NUM_CH = 3;
  localparam int unsigned OUT_CH = 3;
  localparam int unsigned MAP_CH = (NUM_CH < OUT_CH) ? NUM_CH : OUT_CH;

  localparam int unsigned ANG_W = 11;
  localparam int unsigned DRV_W = 12;
  localparam logic [ANG_W-1:0] ANG_FULL  = 11'd1800;
  localparam logic [ANG_W-1:0] ANG_RESET = 11'd900;

  // command codes
  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_SET_ANGLE  = 3'd1;
  localparam logic [2:0] CMD_ENABLE_ONE = 3'd2;
  localparam logic [2:0] CMD_ENABLE_ALL = 3'd3;
  localparam logic [2:0] CMD_SWEEP_SET  = 3'd4;
  localparam logic [2:0] CMD_ALL_ON     = 3'd5;
  localparam logic [2:0] CMD_ALL_OFF    = 3'd6;
  localparam logic [2:0] CMD_SWEEP_TGL  = 3'd7;

  // configuration registers
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_STEP   = 3'd3;
  localparam logic [11:0] RST_PULSE_MIN    = 12'd102;
  localparam logic [11:0] RST_PULSE_MAX    = 12'd512;
  localparam logic [7:0]  RST_SWEEP_PERIOD = 8'd20;
  localparam logic [7:0]  RST_SWEEP_STEP   = 8'd18;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // drive arithmetic: span*angle/1800 = ((span*angle) >> 3) / 225
  localparam int unsigned PROD_W   = DRV_W + ANG_W;
  localparam int unsigned PRE_SH   = 3;
  localparam int unsigned X_W      = PROD_W - PRE_SH;
  localparam int unsigned RECIP_W  = 21;
  localparam int unsigned RECIP_SH = 28;
  localparam int unsigned T_W      = X_W + RECIP_W;
  localparam int unsigned Q0_W     = T_W - RECIP_SH;
  localparam int unsigned REM_W    = X_W + 1;
  localparam logic [RECIP_W-1:0] RECIP  = 21'd1193046;  // floor(2^28 / 225)
  localparam logic [REM_W-1:0]   DIV_LO = 21'd225;

  typedef enum logic [1:0] {
    OP_KEEP,
    OP_LOAD,
    OP_ZERO
  } drv_op_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [3:0]         channel;
    logic               enable_flag;
    logic signed [15:0] angle_tenths;
  } in_item_t;

  typedef struct packed {
    logic [11:0] drive_ch0;
    logic [11:0] drive_ch1;
    logic [11:0] drive_ch2;
    logic [2:0]  enabled_mask;
    logic        sweeping;
  } out_item_t;

  typedef struct packed {
    logic [11:0] pulse_min;
    logic [11:0] pulse_max;
    logic [7:0]  sweep_period;
    logic [7:0]  sweep_step;
  } cfg_t;

  // one classified item on its way to the drive pipeline
  typedef struct packed {
    drv_op_t [NUM_CH-1:0]             op;
    logic [NUM_CH-1:0][ANG_W-1:0]     angle;
    logic [NUM_CH-1:0]                enabled;
    logic                             sweeping;
  } job_t;

endpackage

// ===== rtl/core/sasc_front.sv =====
// Front end: accepts items, updates enable/angle/sweep state, emits drive jobs.
// Depends on sasc_pkg and the core assertion macros.
`include "servo_angle_sweep_controller_core_macros.svh"

module sasc_front import sasc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);

  logic [NUM_CH-1:0]            en_r, en_nxt;
  logic [NUM_CH-1:0][ANG_W-1:0] ang_r, ang_nxt;
  logic                         on_r, on_nxt;
  logic [ANG_W-1:0]             pos_r, pos_nxt;
  logic                         fall_r, fall_nxt;
  logic [7:0]                   cnt_r, cnt_nxt;

  logic [8:0]        cnt_inc;
  logic signed [12:0] pos_s, step_s, moved;
  logic [ANG_W-1:0]  step_pos;
  logic              step_fall;
  logic [ANG_W-1:0]  sat_ang;
  logic              ch_ok;
  drv_op_t [NUM_CH-1:0] op;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign cnt_inc = {1'b0, cnt_r} + 9'd1;
  assign pos_s   = signed'({2'b00, pos_r});
  assign step_s  = signed'({5'b00000, cfg.sweep_step});
  assign moved   = fall_r ? (pos_s - step_s) : (pos_s + step_s);
  assign ch_ok   = 32'(in_data.channel) < NUM_CH;

  // triangle turn points
  always_comb begin
    if (moved >= 13'sd1800) begin
      step_pos  = ANG_FULL;
      step_fall = 1'b1;
    end else if (moved <= 13'sd0) begin
      step_pos  = '0;
      step_fall = 1'b0;
    end else begin
      step_pos  = moved[ANG_W-1:0];
      step_fall = fall_r;
    end
  end

  always_comb begin
    if (in_data.angle_tenths < 16'sd0) begin
      sat_ang = '0;
    end else if (in_data.angle_tenths > 16'sd1800) begin
      sat_ang = ANG_FULL;
    end else begin
      sat_ang = in_data.angle_tenths[ANG_W-1:0];
    end
  end

  always_comb begin
    en_nxt   = en_r;
    ang_nxt  = ang_r;
    on_nxt   = on_r;
    pos_nxt  = pos_r;
    fall_nxt = fall_r;
    cnt_nxt  = cnt_r;
    for (int k = 0; k < NUM_CH; k++) begin
      op[k] = OP_KEEP;
    end
    case (in_data.cmd)
      CMD_TICK: begin
        cnt_nxt = (cnt_inc > {1'b0, cfg.sweep_period}) ? cfg.sweep_period : cnt_inc[7:0];
        if (on_r && (cnt_nxt >= cfg.sweep_period)) begin
          cnt_nxt  = '0;
          pos_nxt  = step_pos;
          fall_nxt = step_fall;
          for (int k = 0; k < NUM_CH; k++) begin
            ang_nxt[k] = step_pos;
            if (en_r[k]) begin
              op[k] = OP_LOAD;
            end
          end
        end
      end
      CMD_SET_ANGLE: begin
        for (int k = 0; k < NUM_CH; k++) begin
          if (ch_ok && (in_data.channel == 4'(k))) begin
            en_nxt[k]  = 1'b1;
            ang_nxt[k] = sat_ang;
            op[k]      = OP_LOAD;
          end
        end
      end
      CMD_ENABLE_ONE: begin
        for (int k = 0; k < NUM_CH; k++) begin
          if (ch_ok && (in_data.channel == 4'(k))) begin
            en_nxt[k] = in_data.enable_flag;
            op[k]     = in_data.enable_flag ? OP_LOAD : OP_ZERO;
          end
        end
      end
      CMD_ENABLE_ALL: begin
        for (int k = 0; k < NUM_CH; k++) begin
          en_nxt[k] = in_data.enable_flag;
          op[k]     = in_data.enable_flag ? OP_LOAD : OP_ZERO;
        end
      end
      CMD_SWEEP_SET: begin
        on_nxt = in_data.enable_flag;
        if (in_data.enable_flag) begin
          pos_nxt  = '0;
          fall_nxt = 1'b0;
        end
      end
      CMD_ALL_ON: begin
        for (int k = 0; k < NUM_CH; k++) begin
          en_nxt[k] = 1'b1;
          op[k]     = OP_LOAD;
        end
      end
      CMD_ALL_OFF: begin
        on_nxt = 1'b0;
        for (int k = 0; k < NUM_CH; k++) begin
          en_nxt[k] = 1'b0;
          op[k]     = OP_ZERO;
        end
      end
      CMD_SWEEP_TGL: begin
        on_nxt = !on_r;
        // turning on enables all channels but leaves their drives alone
        if (!on_r) begin
          pos_nxt  = '0;
          fall_nxt = 1'b0;
          en_nxt   = '1;
        end
      end
      default: begin
        on_nxt = on_r;
      end
    endcase
  end

  always_comb begin
    q_job.op       = op;
    q_job.angle    = ang_nxt;
    q_job.enabled  = en_nxt;
    q_job.sweeping = on_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= '0;
      for (int k = 0; k < NUM_CH; k++) begin
        ang_r[k] <= ANG_RESET;
      end
      on_r   <= 1'b0;
      pos_r  <= '0;
      fall_r <= 1'b0;
      cnt_r  <= '0;
    end else if (q_push) begin
      en_r   <= en_nxt;
      ang_r  <= ang_nxt;
      on_r   <= on_nxt;
      pos_r  <= pos_nxt;
      fall_r <= fall_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  `SASC_ASSERT_SAME(a_pos_range, clk, rst_n, 1'b1, pos_r <= ANG_FULL, "sweep position above full scale")
  `SASC_ASSERT_SAME(a_top_falls, clk, rst_n, pos_r == ANG_FULL, fall_r, "sweep at top but not falling")
  `SASC_ASSERT_SAME(a_bottom_rises, clk, rst_n, fall_r, pos_r != '0, "sweep falling at zero")

endmodule

// ===== rtl/core/sasc_fifo.sv =====
// Two-entry job queue between the front end and the drive pipeline.
// Depends on sasc_pkg.
module sasc_fifo import sasc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t head
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    if (push) begin
      wr_nxt = (wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/core/sasc_back.sv =====
// Drive pipeline: span*angle, reciprocal divide by 1800, drive registers, result register.
// Depends on sasc_pkg and the core assertion macros.
`include "servo_angle_sweep_controller_core_macros.svh"

module sasc_back import sasc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  job_t      q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // stage A: product
  logic                          a_v_r;
  drv_op_t [NUM_CH-1:0]          a_op_r;
  logic [NUM_CH-1:0][PROD_W-1:0] a_p_r, a_p_nxt;
  logic [NUM_CH-1:0]             a_en_r;
  logic                          a_sw_r;
  // stage B: reciprocal product
  logic                          b_v_r;
  drv_op_t [NUM_CH-1:0]          b_op_r;
  logic [NUM_CH-1:0][X_W-1:0]    b_x_r, b_x_nxt;
  logic [NUM_CH-1:0][Q0_W-1:0]   b_q0_r, b_q0_nxt;
  logic [NUM_CH-1:0]             b_en_r;
  logic                          b_sw_r;
  // drive state and result register
  logic [NUM_CH-1:0][DRV_W-1:0]  drv_r, drv_nxt, drv_val;
  logic                          out_v_r;
  out_item_t                     out_data_r, out_nxt;

  logic                          a_free, b_free, o_free;
  logic                          dn;
  logic [DRV_W-1:0]              span;
  logic [NUM_CH-1:0][T_W-1:0]    prod_t;
  logic [NUM_CH-1:0][REM_W-1:0]  rem;
  logic [NUM_CH-1:0][DRV_W-1:0]  quo;
  logic [OUT_CH-1:0][DRV_W-1:0]  drv_pad;
  logic [OUT_CH-1:0]             mask_pad;

  assign o_free = !out_v_r || out_ready;
  assign b_free = !b_v_r || o_free;
  assign a_free = !a_v_r || b_free;
  assign q_pop  = q_valid && a_free;

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // inverted span counts down from pulse_min
  assign dn   = cfg.pulse_max < cfg.pulse_min;
  assign span = dn ? (cfg.pulse_min - cfg.pulse_max) : (cfg.pulse_max - cfg.pulse_min);

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      a_p_nxt[k]  = PROD_W'(span) * PROD_W'(q_head.angle[k]);
      b_x_nxt[k]  = a_p_r[k][PROD_W-1:PRE_SH];
      prod_t[k]   = T_W'(b_x_nxt[k]) * T_W'(RECIP);
      b_q0_nxt[k] = prod_t[k][RECIP_SH +: Q0_W];
      // q0 is at most one short of the quotient
      rem[k]      = REM_W'(b_x_r[k]) - (REM_W'(b_q0_r[k]) * DIV_LO);
      quo[k]      = DRV_W'(b_q0_r[k] + Q0_W'(rem[k] >= DIV_LO));
      drv_val[k]  = dn ? (cfg.pulse_min - quo[k]) : (cfg.pulse_min + quo[k]);
      case (b_op_r[k])
        OP_LOAD: drv_nxt[k] = drv_val[k];
        OP_ZERO: drv_nxt[k] = '0;
        default: drv_nxt[k] = drv_r[k];
      endcase
    end
  end

  always_comb begin
    drv_pad  = '0;
    mask_pad = '0;
    for (int k = 0; k < MAP_CH; k++) begin
      drv_pad[k]  = drv_nxt[k];
      mask_pad[k] = b_en_r[k];
    end
    out_nxt.drive_ch0    = drv_pad[0];
    out_nxt.drive_ch1    = drv_pad[1];
    out_nxt.drive_ch2    = drv_pad[2];
    out_nxt.enabled_mask = mask_pad;
    out_nxt.sweeping     = b_sw_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      out_v_r <= 1'b0;
      drv_r   <= '0;
    end else begin
      if (a_free) begin
        a_v_r <= q_pop;
      end
      if (b_free) begin
        b_v_r <= a_v_r;
      end
      if (o_free) begin
        out_v_r <= b_v_r;
        if (b_v_r) begin
          drv_r <= drv_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_op_r <= q_head.op;
      a_p_r  <= a_p_nxt;
      a_en_r <= q_head.enabled;
      a_sw_r <= q_head.sweeping;
    end
    if (b_free && a_v_r) begin
      b_op_r <= a_op_r;
      b_x_r  <= b_x_nxt;
      b_q0_r <= b_q0_nxt;
      b_en_r <= a_en_r;
      b_sw_r <= a_sw_r;
    end
    if (o_free && b_v_r) begin
      out_data_r <= out_nxt;
    end
  end

  `SASC_ASSERT_NEXT(a_zero_op, clk, rst_n, b_v_r && o_free && (b_op_r[0] == OP_ZERO), drv_r[0] == '0, "disabled channel drive not cleared")
  `SASC_ASSERT_NEXT(a_no_ghost, clk, rst_n, !out_v_r && !b_v_r, !out_v_r, "result appeared without a job")
  `SASC_ASSERT_SAME(a_out_tracks, clk, rst_n, out_v_r, out_data_r.drive_ch0 == drv_r[0], "result drive differs from drive state")

endmodule

// ===== rtl/core/servo_angle_sweep_controller_core.sv =====
// Three-channel servo controller with triangle sweep: top level.
// Holds the configuration registers; depends on sasc_pkg, sasc_front, sasc_fifo, sasc_back.
//
// Input channel (in_valid/in_ready/in_data): one item is a millisecond tick or a
// command. Each accepted item gives exactly one result on the output channel
// (out_valid/out_ready/out_data): the three drive counts after the item, the
// enable mask and the sweep flag.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is always high;
// index 0 pulse_min, 1 pulse_max, 2 sweep_period_ms, 3 sweep_step; other indexes
// are dropped. Write only while no item is in flight.
// An accepted item is written into the job queue, then passes the span multiply
// stage, the reciprocal multiply stage and the result register, where out_valid
// rises. Throughput: one item per cycle while results are taken; the front end
// updates channel state on acceptance and each pipeline stage holds one item.
// Receiver stall: the result register holds, the pipeline fills, then the
// two-entry queue fills and in_ready drops. in_ready returns the cycle after
// a result is taken.
// Reset (rst_n low, synchronous): all channels off, angles 90 degrees, drives 0,
// sweep off at position 0, registers back to 102/512/20/18. No clearing pass.
module servo_angle_sweep_controller_core import sasc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r;
  logic q_full, q_push, q_pop, q_valid;
  job_t q_job, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_min    <= RST_PULSE_MIN;
      cfg_r.pulse_max    <= RST_PULSE_MAX;
      cfg_r.sweep_period <= RST_SWEEP_PERIOD;
      cfg_r.sweep_step   <= RST_SWEEP_STEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PULSE_MIN:    cfg_r.pulse_min    <= cfg_data;
        REG_PULSE_MAX:    cfg_r.pulse_max    <= cfg_data;
        REG_SWEEP_PERIOD: cfg_r.sweep_period <= cfg_data[7:0];
        REG_SWEEP_STEP:   cfg_r.sweep_step   <= cfg_data[7:0];
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  sasc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  sasc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  sasc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_servo_angle_sweep_controller_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for servo_angle_sweep_controller_core: random and directed
// commands, ticks and register writes against a cycle-free drive predictor.
// Depends on sasc_pkg and the core RTL only.
module tb_servo_angle_sweep_controller_core;
  import sasc_pkg::*;

  localparam int ANGLE_FULL_I  = int'(ANG_FULL);
  localparam int ANGLE_RESET_I = int'(ANG_RESET);
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int PHASE_ITEMS   = 205;
  localparam int MAX_PRINTED   = 100;
  localparam int IN_W          = $bits(in_item_t);
  // index outside the register map, must be dropped by the block
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Predicts the status item returned for every accepted command and checks results.
  class servo_scoreboard;
    int unsigned pulse_min, pulse_max, sweep_period, sweep_step;
    bit          ch_on    [NUM_CH];
    int unsigned ch_angle [NUM_CH];
    logic [DRV_W-1:0] ch_drive [NUM_CH];
    bit          sweep_on, sweep_falling;
    int          sweep_pos;
    int unsigned tick_count;
    out_item_t   expected_status_q[$];
    int          errors;

    function new();
      pulse_min    = RST_PULSE_MIN;
      pulse_max    = RST_PULSE_MAX;
      sweep_period = RST_SWEEP_PERIOD;
      sweep_step   = RST_SWEEP_STEP;
      for (int k = 0; k < NUM_CH; k++) begin
        ch_on[k]    = 1'b0;
        ch_angle[k] = ANGLE_RESET_I;
        ch_drive[k] = '0;
      end
      sweep_on      = 1'b0;
      sweep_falling = 1'b0;
      sweep_pos     = 0;
      tick_count    = 0;
      errors        = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function int pending();
      return expected_status_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PULSE_MIN:    pulse_min    = val;
        REG_PULSE_MAX:    pulse_max    = val;
        REG_SWEEP_PERIOD: sweep_period = val[7:0];
        REG_SWEEP_STEP:   sweep_step   = val[7:0];
        default: ;
      endcase
    endfunction

    // min + span*angle/1800, span taken downward when max is below min
    function logic [DRV_W-1:0] pulse_for_angle(int unsigned a);
      int unsigned span;
      if (pulse_max >= pulse_min) begin
        span = pulse_max - pulse_min;
        return DRV_W'(pulse_min + (span * a) / ANGLE_FULL_I);
      end
      span = pulse_min - pulse_max;
      return DRV_W'(pulse_min - (span * a) / ANGLE_FULL_I);
    endfunction

    function void store_angle(int k, int a);
      if (a < 0) a = 0;
      if (a > ANGLE_FULL_I) a = ANGLE_FULL_I;
      ch_angle[k] = a;
      if (ch_on[k]) ch_drive[k] = pulse_for_angle(a);
    endfunction

    function void apply_enable(int k, bit on);
      ch_on[k] = on;
      if (on) store_angle(k, ch_angle[k]);
      else ch_drive[k] = '0;
    endfunction

    function void advance_tick();
      if (tick_count + 1 > sweep_period) tick_count = sweep_period;
      else tick_count++;
      if (!sweep_on || tick_count < sweep_period) return;
      tick_count = 0;
      if (sweep_falling) sweep_pos -= int'(sweep_step);
      else sweep_pos += int'(sweep_step);
      if (sweep_pos >= ANGLE_FULL_I) begin
        sweep_pos     = ANGLE_FULL_I;
        sweep_falling = 1'b1;
      end
      if (sweep_pos <= 0) begin
        sweep_pos     = 0;
        sweep_falling = 1'b0;
      end
      for (int k = 0; k < NUM_CH; k++) store_angle(k, sweep_pos);
    endfunction

    function void note_item(in_item_t it);
      int ang;
      logic [DRV_W-1:0] d [3];
      logic [2:0] m;
      out_item_t e;
      ang = $signed(it.angle_tenths);
      case (it.cmd)
        CMD_TICK: advance_tick();
        CMD_SET_ANGLE: begin
          if (it.channel < NUM_CH) begin
            ch_on[it.channel] = 1'b1;
            store_angle(it.channel, ang);
          end
        end
        CMD_ENABLE_ONE: begin
          if (it.channel < NUM_CH) apply_enable(it.channel, it.enable_flag);
        end
        CMD_ENABLE_ALL: for (int k = 0; k < NUM_CH; k++) apply_enable(k, it.enable_flag);
        CMD_SWEEP_SET: begin
          sweep_on = it.enable_flag;
          if (sweep_on) begin
            sweep_pos     = 0;
            sweep_falling = 1'b0;
          end
        end
        CMD_ALL_ON: for (int k = 0; k < NUM_CH; k++) apply_enable(k, 1'b1);
        CMD_ALL_OFF: begin
          for (int k = 0; k < NUM_CH; k++) apply_enable(k, 1'b0);
          sweep_on = 1'b0;
        end
        CMD_SWEEP_TGL: begin
          sweep_on = !sweep_on;
          // drives are not reloaded here, only the enables
          if (sweep_on) begin
            sweep_pos     = 0;
            sweep_falling = 1'b0;
            for (int k = 0; k < NUM_CH; k++) ch_on[k] = 1'b1;
          end
        end
        default: ;
      endcase
      for (int k = 0; k < 3; k++) begin
        d[k] = '0;
        m[k] = 1'b0;
        if (k < NUM_CH) begin
          d[k] = ch_drive[k];
          m[k] = ch_on[k];
        end
      end
      e.drive_ch0    = d[0];
      e.drive_ch1    = d[1];
      e.drive_ch2    = d[2];
      e.enabled_mask = m;
      e.sweeping     = sweep_on;
      expected_status_q.push_back(e);
    endfunction

    task check_result(out_item_t got);
      out_item_t e;
      if (expected_status_q.size() == 0) begin
        report($sformatf("result item with nothing outstanding: %h", got));
        return;
      end
      e = expected_status_q.pop_front();
      if (got.drive_ch0 !== e.drive_ch0)
        report($sformatf("drive_ch0 got %0d expected %0d", got.drive_ch0, e.drive_ch0));
      if (got.drive_ch1 !== e.drive_ch1)
        report($sformatf("drive_ch1 got %0d expected %0d", got.drive_ch1, e.drive_ch1));
      if (got.drive_ch2 !== e.drive_ch2)
        report($sformatf("drive_ch2 got %0d expected %0d", got.drive_ch2, e.drive_ch2));
      if (got.enabled_mask !== e.enabled_mask)
        report($sformatf("enabled_mask got %b expected %b", got.enabled_mask, e.enabled_mask));
      if (got.sweeping !== e.sweeping)
        report($sformatf("sweeping got %b expected %b", got.sweeping, e.sweeping));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  servo_scoreboard sb = new();
  int send_idle_pct = 28;
  int recv_idle_pct = 55;
  int stalled_cycles = 0;
  bit hold_off_pending = 1'b0;

  servo_angle_sweep_controller_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // monitor: everything sampled at the edge where the handshake happens
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_item(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
    if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
      stalled_cycles = 0;
    else
      stalled_cycles++;
  end

  initial begin : watchdog
    while (stalled_cycles < STALL_LIMIT) @(posedge clk);
    $display("servo_angle_sweep_controller_core regression: fail");
    $finish;
  end

  // result side; one long hold-off on request so the block backs up into in_ready
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic in_item_t cmd_item(logic [2:0] cmd, logic [3:0] ch, logic flag,
                                        logic [15:0] ang);
    in_item_t it;
    it.cmd          = cmd;
    it.channel      = ch;
    it.enable_flag  = flag;
    it.angle_tenths = ang;
    return it;
  endfunction

  function automatic in_item_t random_cmd_item();
    in_item_t it;
    int unsigned roll;
    int unsigned sel;
    it   = in_item_t'(IN_W'($urandom()));
    roll = $urandom_range(99);
    if (roll < 60) begin
      it.cmd = CMD_TICK;
    end else if (roll < 75) begin
      it.cmd = CMD_SET_ANGLE;
      it.channel = ($urandom_range(99) < 90) ? 4'($urandom_range(NUM_CH - 1, 0))
                                             : 4'($urandom_range(15, NUM_CH));
      sel = $urandom_range(9);
      case (sel)
        0, 1, 2, 3, 4, 5: it.angle_tenths = 16'($urandom_range(ANGLE_FULL_I, 0));
        6, 7: it.angle_tenths = 16'($urandom());
        8: it.angle_tenths = ($urandom_range(1)) ? 16'(ANGLE_FULL_I + 1) : 16'hFFFF;
        default: it.angle_tenths = ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
      endcase
    end else if (roll < 81) begin
      it.cmd = CMD_ENABLE_ONE;
      if ($urandom_range(99) < 85) it.channel = 4'($urandom_range(NUM_CH - 1, 0));
    end else if (roll < 84) begin
      it.cmd = CMD_ENABLE_ALL;
    end else if (roll < 90) begin
      it.cmd = CMD_SWEEP_SET;
      it.enable_flag = ($urandom_range(99) < 85);
    end else if (roll < 94) begin
      it.cmd = CMD_ALL_ON;
    end else if (roll < 96) begin
      it.cmd = CMD_ALL_OFF;
    end else begin
      it.cmd = CMD_SWEEP_TGL;
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(input int unsigned pmin, input int unsigned pmax,
                             input int unsigned period, input int unsigned step);
    put_reg(REG_PULSE_MIN, CFG_DATA_W'(pmin));
    put_reg(REG_PULSE_MAX, CFG_DATA_W'(pmax));
    put_reg(REG_SWEEP_PERIOD, CFG_DATA_W'(period));
    put_reg(REG_SWEEP_STEP, CFG_DATA_W'(step));
    put_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  // one edge first so the item accepted at the current edge is already noted
  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send_item(random_cmd_item());
    in_valid <= 1'b0;
    wait_drained();
  endtask

  initial begin : main
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass at reset register values
    send_item(cmd_item(CMD_TICK,       4'd0,  1'b0, 16'h0000));
    send_item(cmd_item(CMD_SET_ANGLE,  4'd0,  1'b0, 16'h8000));
    send_item(cmd_item(CMD_SET_ANGLE,  4'd1,  1'b1, 16'h7FFF));
    send_item(cmd_item(CMD_SET_ANGLE,  4'd2,  1'b0, 16'hFFFF));
    send_item(cmd_item(CMD_SET_ANGLE,  4'd2,  1'b1, 16'd1801));
    send_item(cmd_item(CMD_SET_ANGLE,  4'd3,  1'b1, 16'd900));
    send_item(cmd_item(CMD_SET_ANGLE,  4'd15, 1'b0, 16'd1000));
    send_item(cmd_item(CMD_ENABLE_ONE, 4'd1,  1'b0, 16'h5555));
    send_item(cmd_item(CMD_ENABLE_ONE, 4'd1,  1'b1, 16'hAAAA));
    send_item(cmd_item(CMD_ENABLE_ONE, 4'd12, 1'b0, 16'd0));
    send_item(cmd_item(CMD_ENABLE_ALL, 4'd5,  1'b0, 16'd0));
    send_item(cmd_item(CMD_ENABLE_ALL, 4'd9,  1'b1, 16'd1800));
    send_item(cmd_item(CMD_ALL_OFF,    4'd0,  1'b1, 16'd0));
    send_item(cmd_item(CMD_ALL_ON,     4'd0,  1'b0, 16'd0));
    send_item(cmd_item(CMD_SWEEP_SET,  4'd0,  1'b1, 16'd0));
    send_item(cmd_item(CMD_SWEEP_SET,  4'd0,  1'b0, 16'd0));
    send_item(cmd_item(CMD_SWEEP_TGL,  4'd0,  1'b0, 16'd0));
    send_item(cmd_item(CMD_ALL_OFF,    4'd0,  1'b0, 16'd0));
    // toggling on again enables channels whose drives are still zero
    send_item(cmd_item(CMD_SWEEP_TGL,  4'd3,  1'b1, 16'd0));
    send_item(cmd_item(CMD_TICK,       4'd0,  1'b1, 16'hFFFF));
    send_item(cmd_item(CMD_SWEEP_TGL,  4'd0,  1'b0, 16'd0));
    send_item(cmd_item(CMD_TICK,       4'd8,  1'b0, 16'd0));
    in_valid <= 1'b0;
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: load_config(0, 4095, 1, 255);
        1: load_config(4095, 0, 1, 1);
        2: load_config($urandom_range(4095), $urandom_range(4095), $urandom_range(4, 1),
                       $urandom_range(255, 100));
        3: begin
          sel_equal_span: load_config(1000, 1000, 255, 18);
        end
        4: load_config($urandom_range(4095), $urandom_range(4095), $urandom_range(3, 1),
                       $urandom_range(255, 1));
        default: load_config(RST_PULSE_MIN, RST_PULSE_MAX, 2, $urandom_range(200, 60));
      endcase
      if (p < 2) begin
        send_idle_pct = 28;
        recv_idle_pct = 55;
      end else if (p < 4) begin
        send_idle_pct = 55;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 4) hold_off_pending = 1'b1;
      run_random(PHASE_ITEMS);
    end

    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected result items never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("servo_angle_sweep_controller_core regression: pass");
    else
      $display("servo_angle_sweep_controller_core regression: fail");
    $finish;
  end

endmodule
